// ===== src/swmf_pkg.sv =====
// Shared widths, constants and controller/datapath handshake types for the median filter.
package swmf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 5;
  localparam int WINDOW_MAX_DEF = 16;
  localparam int WINDOW_RESET   = 5;
  localparam int PASS_BELOW     = 3;

  typedef struct packed {
    logic load;     // capture sample, read the slot about to be overwritten
    logic store;    // write sample into the ring, advance position
    logic remove;   // drop the overwritten sample from the sorted row
    logic insert;   // insert the new sample into the sorted row
    logic pick_lo;  // latch the lower middle value
    logic emit;     // load the output register
    logic clear;    // window written: empty the store
  } swmf_cmd_t;

  typedef struct packed {
    logic full;     // fill count has reached the window
    logic pass;     // fewer than three samples held
  } swmf_sts_t;

endpackage

// ===== src/swmf_if.sv =====
// Valid/ready channel interfaces for samples, filtered results and the window register.
interface swmf_sample_if;
  import swmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swmf_filtered_if;
  import swmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] filtered;
  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

interface swmf_cfg_if;
  import swmf_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_length;
  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

// ===== src/swmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module swmf_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/swmf_dp.sv =====
// Datapath: sample ring, sorted row of held samples, fill count and median pick.
module swmf_dp
  import swmf_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swmf_cmd_t           cmd,
  output swmf_sts_t           sts,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [CFG_W-1:0]    cfg_window,
  output logic [SAMPLE_W-1:0] filtered
);

  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int IW   = $clog2(WINDOW_MAX);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  function automatic logic [CW-1:0] clamp_win(input logic [CFG_W-1:0] v);
    logic [CMPW-1:0] ve;
    ve = CMPW'(v);
    if (ve == '0) begin
      return CW'(1);
    end else if (ve > CMPW'(WINDOW_MAX)) begin
      return CW'(WINDOW_MAX);
    end
    return CW'(ve);
  endfunction

  logic [CW-1:0]       win_r, win_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       wp_r, wp_nxt;
  logic [SAMPLE_W-1:0] s_r, a_r, res_r;
  logic [SAMPLE_W-1:0] sorted_r   [WINDOW_MAX];
  logic [SAMPLE_W-1:0] sorted_nxt [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] gt;
  logic [SAMPLE_W-1:0] old_sample;
  logic [CW-1:0]       wp_inc;
  logic [CW-1:0]       mid_w, lo_w;
  logic [IW-1:0]       idx_lo, idx_hi;
  logic [SAMPLE_W:0]   pair_sum;
  logic [SAMPLE_W-1:0] med;

  swmf_ram #(
    .W     (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wp_r),
    .wdata (s_r),
    .re    (cmd.load),
    .raddr (wp_r),
    .rdata (old_sample)
  );

  assign sts.full = (count_r == win_r);
  assign sts.pass = (count_r < CW'(PASS_BELOW));

  // Ring position wraps at the configured window
  assign wp_inc = CW'(wp_r) + CW'(1);

  always_comb begin
    win_nxt   = win_r;
    count_nxt = count_r;
    wp_nxt    = wp_r;
    if (cmd.clear) begin
      win_nxt   = clamp_win(cfg_window);
      count_nxt = '0;
      wp_nxt    = '0;
    end else begin
      if (cmd.store) begin
        wp_nxt = (wp_inc == win_r) ? '0 : wp_inc[IW-1:0];
      end
      if (cmd.remove) begin
        count_nxt = count_r - CW'(1);
      end else if (cmd.insert) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  // Slots at or past the fill count act as larger than any sample
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      gt[i] = (CW'(i) >= count_r) || (sorted_r[i] > s_r);
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      sorted_nxt[i] = sorted_r[i];
    end
    if (cmd.remove) begin
      // first slot >= old sample holds it; everything from there moves down one
      for (int i = 0; i < WINDOW_MAX - 1; i++) begin
        if (sorted_r[i] >= old_sample) begin
          sorted_nxt[i] = sorted_r[i + 1];
        end
      end
    end else if (cmd.insert) begin
      if (gt[0]) begin
        sorted_nxt[0] = s_r;
      end
      for (int i = 1; i < WINDOW_MAX; i++) begin
        if (gt[i]) begin
          sorted_nxt[i] = gt[i - 1] ? sorted_r[i - 1] : s_r;
        end
      end
    end
  end

  assign mid_w  = count_r >> 1;
  assign lo_w   = (mid_w == '0) ? '0 : mid_w - CW'(1);
  assign idx_lo = lo_w[IW-1:0];
  assign idx_hi = mid_w[IW-1:0];

  assign pair_sum = {1'b0, a_r} + {1'b0, sorted_r[idx_hi]};
  assign med      = count_r[0] ? sorted_r[idx_hi] : pair_sum[SAMPLE_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= clamp_win(CFG_W'(WINDOW_RESET));
      count_r <= '0;
      wp_r    <= '0;
    end else begin
      win_r   <= win_nxt;
      count_r <= count_nxt;
      wp_r    <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      sorted_r[i] <= sorted_nxt[i];
    end
    if (cmd.load) begin
      s_r <= in_sample;
    end
    if (cmd.pick_lo) begin
      a_r <= sorted_r[idx_lo];
    end
    if (cmd.emit) begin
      res_r <= sts.pass ? s_r : med;
    end
  end

  assign filtered = res_r;

endmodule

// ===== src/swmf_ctrl.sv =====
// Controller: sequences one sample through ring update, sorted-row update and median pick.
module swmf_ctrl
  import swmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  swmf_sts_t sts,
  output swmf_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_MA   = 3'd3;
  localparam logic [2:0] S_MB   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_busy  = out_valid_r && !out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.clear = cfg_valid;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.store  = 1'b1;
        cmd.remove = sts.full;
        state_nxt  = S_INS;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_MA;
      end
      S_MA: begin
        cmd.pick_lo = !sts.pass;
        state_nxt   = S_MB;
      end
      S_MB: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/sliding_window_median_filter.sv =====
// Sliding-window median filter for 16-bit unsigned light samples: each accepted sample
// yields one result, the median of the last window_length samples (middle pair
// averaged and truncated for an even count), or the sample itself while fewer than
// three are held. A new sample is accepted only once the controller is done with the
// last one: the accepting cycle reads the ring slot about to be overwritten, then a
// step removes that sample from the sorted row, the next inserts the new sample, and
// the last steps read the lower and upper middle of the sorted row. A stalled result
// holds the controller in its last step until the output register frees up. The next
// sample is taken once the controller is back in idle, even while the last result
// still waits in the output register. Writing window_length (clamped to 1..WINDOW_MAX)
// empties the window; the ring itself needs no clearing pass.
module sliding_window_median_filter
  import swmf_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  swmf_sample_if.sink     in_if,
  swmf_filtered_if.source out_if,
  swmf_cfg_if.sink        cfg_if
);

  swmf_cmd_t cmd;
  swmf_sts_t sts;

  swmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swmf_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_if.sample),
    .cfg_window (cfg_if.window_length),
    .filtered   (out_if.filtered)
  );

endmodule

// ===== src/swmf_checker.sv =====
// Port-level checks on the median filter, bound to the top level.
module swmf_assert
  import swmf_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                cfg_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_filtered
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_filtered))
    else $error("result changed while stalled");

  // one sample at a time: input closes right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a sample is in flight");

  // the window register is writable exactly when a sample may enter
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready == cfg_ready))
    else $error("config and input readiness disagree");

endmodule

bind sliding_window_median_filter swmf_assert u_swmf_assert (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .cfg_ready    (cfg_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_filtered (out_if.filtered)
);

// ===== sim/swmf_checker.sv =====
// Median filter checker: tracks the window, predicts each filtered sample and compares.
module swmf_checker
  import swmf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  swmf_sample_if   in_ch,
  swmf_filtered_if out_ch,
  swmf_cfg_if      cfg_ch,
  output int       mismatches,
  output int       outstanding
);

  logic [CFG_W-1:0]    window;
  logic [SAMPLE_W-1:0] ring [WINDOW_MAX_DEF];
  int                  wr_pos;
  int                  held;
  logic [SAMPLE_W-1:0] expected_filtered [$];
  logic [SAMPLE_W-1:0] want;

  function automatic logic [CFG_W-1:0] clamp_window(input logic [CFG_W-1:0] v);
    if (v == 0) return CFG_W'(1);
    if (v > WINDOW_MAX_DEF) return CFG_W'(WINDOW_MAX_DEF);
    return v;
  endfunction

  task automatic empty_window();
    foreach (ring[i]) ring[i] = '0;
    wr_pos = 0;
    held   = 0;
  endtask

  // Store the sample, then rank entries 0..held-1 of the ring.
  function automatic logic [SAMPLE_W-1:0] predict_filtered(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] row [WINDOW_MAX_DEF];
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W:0]   pair;
    int                  j;
    int                  mid;
    ring[wr_pos] = s;
    wr_pos = wr_pos + 1;
    if (wr_pos >= window) wr_pos = 0;
    if (held < window) held = held + 1;
    if (held < PASS_BELOW) return s;
    for (int i = 0; i < held; i++) begin
      v = ring[i];
      j = i;
      while (j > 0 && row[j-1] > v) begin
        row[j] = row[j-1];
        j--;
      end
      row[j] = v;
    end
    mid = held / 2;
    if (held % 2 == 0) begin
      pair = {1'b0, row[mid-1]} + {1'b0, row[mid]};
      return pair[SAMPLE_W:1];
    end
    return row[mid];
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] exp_v,
                                 input logic [SAMPLE_W-1:0] got_v);
    if (mismatches < 10)
      $display("checker: %s at %0t: expected filtered %0d, got %0d", what, $time, exp_v,
               got_v);
    mismatches++;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    window      = CFG_W'(WINDOW_RESET);
    empty_window();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      window = CFG_W'(WINDOW_RESET);
      empty_window();
      expected_filtered.delete();
    end else begin
      // results leave before the same-edge sample is predicted
      if (out_ch.valid && out_ch.ready) begin
        if (expected_filtered.size() == 0) begin
          report_mismatch("result with nothing pending", 'x, out_ch.filtered);
        end else begin
          want = expected_filtered.pop_front();
          if (out_ch.filtered !== want) report_mismatch("wrong result", want, out_ch.filtered);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        window = clamp_window(cfg_ch.window_length);
        empty_window();
      end
      if (in_ch.valid && in_ch.ready)
        expected_filtered.push_back(predict_filtered(in_ch.sample));
    end
    outstanding = expected_filtered.size();
  end

endmodule

// ===== sim/sliding_window_median_filter_tb.sv =====
// Testbench top: clock, reset, sample and window stimulus, result back-pressure, verdict.
module sliding_window_median_filter_tb;
  import swmf_pkg::*;

  logic clk;
  logic rst_n;
  logic steady;
  int   mismatches;
  int   outstanding;

  swmf_sample_if   in_ch ();
  swmf_filtered_if out_ch ();
  swmf_cfg_if      cfg_ch ();

  sliding_window_median_filter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  swmf_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 19);
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SAMPLE_W'($urandom_range(15));
      4:       return SAMPLE_W'(16'hFFFF - $urandom_range(15));
      default: return SAMPLE_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_window();
    case ($urandom_range(7))
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'(2);
      3:       return CFG_W'(3);
      4:       return CFG_W'(WINDOW_MAX_DEF);
      5:       return '1;
      default: return CFG_W'($urandom_range(31));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(99) < 19) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.sample = s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    drain();
    cfg_ch.valid         = 1'b1;
    cfg_ch.window_length = w;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    int burst;
    int total;
    int phase;
    rst_n                = 1'b0;
    steady               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample         = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.window_length = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset window of 5: two pass-throughs, odd median, even pair, wrap
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    // zero is raised to one: everything passes
    write_window(CFG_W'(0));
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h3039);
    write_window(CFG_W'(2));
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0F0F);
    // even window: top-end sum needs the carry, odd sum truncates
    write_window(CFG_W'(4));
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    // above the maximum is cut down
    write_window(CFG_W'(17));
    repeat (4) send_sample(pick_sample());

    total = 0;
    phase = 0;
    while (total < 630) begin
      write_window(phase == 0 ? CFG_W'(31) : pick_window());
      steady = (phase == 2);
      burst  = $urandom_range(15, 60);
      for (int k = 0; k < burst; k++) begin
        send_sample(pick_sample());
        total++;
      end
      steady = 1'b0;
      phase++;
    end

    drain();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
